// File: rtl/qslb_pkg.sv
// ----------------------------------------------------------------------------
// qslb_pkg
// Shared widths, types and codes for the quad shell local basis block.
// ----------------------------------------------------------------------------
package qslb_pkg;

    localparam int COORD_W       = 32;   // position / displacement width
    localparam int SUM_W         = 35;   // axis sum width, wraps modulo 2^35
    localparam int NRM_W         = 30;   // rescaled magnitude width
    localparam int MAG_W         = 62;   // working magnitude width
    localparam int UNIT_W        = 32;   // unit vector component width
    localparam int UNIT_FRAC_DEF = 30;   // default fraction bits of results

    // Corner sign masks, one bit per slot, 1 = subtract
    localparam logic [3:0] FIRST_NEG  = 4'b1001;
    localparam logic [3:0] SECOND_NEG = 4'b0011;

    // Axis numbers
    localparam logic [1:0] AXIS_FIRST  = 2'd0;
    localparam logic [1:0] AXIS_SECOND = 2'd1;
    localparam logic [1:0] AXIS_NORMAL = 2'd2;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        t_sum [2:0] first;
        t_sum [2:0] second;
    } t_frame;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_N,
        PH_S
    } t_phase;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RESCALE,
        BK_XMUL,
        BK_XACC,
        BK_SQMUL,
        BK_SQACC,
        BK_ROOT,
        BK_DIV,
        BK_OUT
    } t_bk_state;

endpackage

// File: rtl/quad_shell_local_basis.sv
// ----------------------------------------------------------------------------
// quad_shell_local_basis
// Orthonormal local frame of a four-node quadrilateral shell.
// ----------------------------------------------------------------------------
// Send the four corner nodes of a shell as stream transactions, one per node,
// with tlast on the last one. Each node's current coordinate (position plus
// trial displacement, Q16.16) is added with the signs of its corner into two
// in-plane axis sums; a node sent twice counts twice. The tlast transaction
// closes the frame: three result transactions follow, axis 0 (first in-plane
// axis), axis 1 (second axis re-formed as normal x first) and axis 2 (the
// normal, with tlast), as Q2.30 unit vectors. A zero-length vector is flagged
// degenerate with zero components. Nodes are taken one per cycle while the
// two-frame queue has room. Frame work runs on one shared multiplier, a
// bit-pair square root and three parallel radix-2 dividers; rescaling
// shifts up to four bits a cycle. A zero-length axis skips its root and
// division and is much quicker.
// ----------------------------------------------------------------------------
module quad_shell_local_basis import qslb_pkg::*; #(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // node input
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [191:0]  i_s_axis_tdata,  // pos_x, pos_y, pos_z, disp_x, disp_y, disp_z
    input  logic [1:0]    i_s_axis_tuser,  // node_slot
    input  logic          i_s_axis_tlast,  // final_node
    // frame output
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [95:0]   o_m_axis_tdata,  // unit_x, unit_y, unit_z
    output logic [2:0]    o_m_axis_tuser,  // axis_number[1:0], degenerate
    output logic          o_m_axis_tlast   // frame_end
);

    logic                   q_full;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_valid;
    t_frame                 q_wdata;
    t_frame                 q_rdata;
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] disp;
    logic [1:0]             out_axis;
    logic [2:0][UNIT_W-1:0] out_unit;
    logic                   out_degen;

    assign pos  = i_s_axis_tdata[3*COORD_W-1:0];
    assign disp = i_s_axis_tdata[6*COORD_W-1:3*COORD_W];

    // Front: accumulate corners, hand over a completed frame
    qslb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_slot   (i_s_axis_tuser),
        .i_pos    (pos),
        .i_disp   (disp),
        .i_last   (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_frame  (q_wdata)
    );

    // Queue of up to two frames so nodes keep flowing during frame work
    qslb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // Back: frame sequencer and result register
    qslb_back #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_axis    (out_axis),
        .o_unit    (out_unit),
        .o_degen   (out_degen),
        .o_end     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = out_unit;
    assign o_m_axis_tuser = {out_degen, out_axis};

endmodule

// File: rtl/qslb_front.sv
// ----------------------------------------------------------------------------
// qslb_front
// Accepts node transactions and accumulates the two in-plane axis sums.
// ----------------------------------------------------------------------------
module qslb_front import qslb_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_slot,
    input  logic [2:0][COORD_W-1:0]     i_pos,
    input  logic [2:0][COORD_W-1:0]     i_disp,
    input  logic                        i_last,
    input  logic                        i_q_full,
    output logic                        o_push,
    output t_frame                      o_frame
);

    t_sum [2:0] r_first;
    t_sum [2:0] r_second;
    t_sum [2:0] n_first;
    t_sum [2:0] n_second;
    logic       accept;

    always_comb begin
        logic signed [COORD_W:0] c;
        t_sum                    ce;
        for (int i = 0; i < 3; i++) begin
            c  = $signed({i_pos[i][COORD_W-1], i_pos[i]})
               + $signed({i_disp[i][COORD_W-1], i_disp[i]});
            ce = t_sum'(c);
            n_first[i]  = FIRST_NEG[i_slot]  ? r_first[i]  - ce : r_first[i]  + ce;
            n_second[i] = SECOND_NEG[i_slot] ? r_second[i] - ce : r_second[i] + ce;
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_last;
    assign o_frame = '{first: n_first, second: n_second};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_first  <= '0;
                r_second <= '0;
            end else begin
                r_first  <= n_first;
                r_second <= n_second;
            end
        end
    end

endmodule

// File: rtl/qslb_fifo.sv
// ----------------------------------------------------------------------------
// qslb_fifo
// Two-entry queue of completed axis sums between front and back.
// ----------------------------------------------------------------------------
module qslb_fifo import qslb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_data
);

    t_frame     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: rtl/qslb_back.sv
// ----------------------------------------------------------------------------
// qslb_back
// Frame sequencer: rescale, cross products, root and divisions, result reg.
// ----------------------------------------------------------------------------
module qslb_back import qslb_pkg::*; #(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_frame                  i_q_data,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_axis,
    output logic [2:0][UNIT_W-1:0]  o_unit,
    output logic                    o_degen,
    output logic                    o_end
);

    localparam int Q_W   = UNIT_FRAC_BITS + 1;
    localparam int NUM_W = NRM_W + UNIT_FRAC_BITS + 1;
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam logic [2:0] XSTEP_LAST = 3'd5;
    localparam logic [2:0] SQSTEP_LAST = 3'd2;

    t_bk_state r_state, n_state;
    t_phase    r_phase;
    logic [1:0] r_emit;
    logic [2:0] r_step;

    t_sum [2:0]         r_bsum;
    logic               r_vs [3];
    logic [MAG_W-1:0]   r_vm [3];
    logic               r_as [3];
    logic [NRM_W-1:0]   r_am [3];
    logic               r_bs [3];
    logic [NRM_W-1:0]   r_bm [3];
    logic               r_ns [3];
    logic [NRM_W-1:0]   r_nm [3];
    logic               r_ss [3];
    logic [NRM_W-1:0]   r_sm [3];

    logic [2*NRM_W-1:0] r_prod;
    logic               r_pneg;
    logic signed [MAG_W-1:0] r_acc;
    logic [MAG_W-1:0]   r_sumsq;
    logic [MAG_W-1:0]   r_x;
    logic [MAG_W-1:0]   r_root;
    logic [MAG_W-1:0]   r_bitv;
    logic [NRM_W:0]     r_len;
    logic [NRM_W:0]     r_rem [3];
    logic [Q_W-1:0]     r_num [3];
    logic [Q_W-1:0]     r_quo [3];
    logic [CNT_W-1:0]   r_cnt;
    logic               r_degen;

    logic                   r_out_valid;
    logic [1:0]             r_out_axis;
    logic [2:0][UNIT_W-1:0] r_out_unit;
    logic                   r_out_degen;
    logic                   r_out_end;

    // combinational
    logic [MAG_W-1:0]   vor;
    logic               rs_done;
    logic [1:0]         idx_i, idx_j, idx_k;
    logic               p_s [3];
    logic [NRM_W-1:0]   p_m [3];
    logic               q_s [3];
    logic [NRM_W-1:0]   q_m [3];
    logic               e_s [3];
    logic [NRM_W-1:0]   e_m [3];
    logic [NRM_W-1:0]   mul_a, mul_b;
    logic [2*NRM_W-1:0] mul_p;
    logic               x_neg;
    logic signed [MAG_W-1:0] acc_new;
    logic [MAG_W-1:0]   sumsq_new;
    logic [MAG_W:0]     rt_trial;
    logic               rt_ge;
    logic [MAG_W-1:0]   root_new;
    logic               out_load;

    // Rescale: bring the largest magnitude into [2^29, 2^30); an all-zero vector counts as done
    always_comb begin
        vor     = r_vm[0] | r_vm[1] | r_vm[2];
        rs_done = (vor == '0) ||
                  (!(|vor[MAG_W-1:NRM_W]) && vor[NRM_W-1]);
    end

    // Cross product term selection
    always_comb begin
        idx_i = r_step[2:1];
        unique case (idx_i)
            2'd0:    begin idx_j = 2'd1; idx_k = 2'd2; end
            2'd1:    begin idx_j = 2'd2; idx_k = 2'd0; end
            default: begin idx_j = 2'd0; idx_k = 2'd1; end
        endcase
        for (int i = 0; i < 3; i++) begin
            if (r_phase == PH_S) begin
                p_s[i] = r_ns[i]; p_m[i] = r_nm[i];
                q_s[i] = r_as[i]; q_m[i] = r_am[i];
            end else begin
                p_s[i] = r_as[i]; p_m[i] = r_am[i];
                q_s[i] = r_bs[i]; q_m[i] = r_bm[i];
            end
        end
        x_neg = r_step[0] ? (p_s[idx_k] ^ q_s[idx_j] ^ 1'b1) : (p_s[idx_j] ^ q_s[idx_k]);
    end

    // Vector being emitted
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            priority if (r_emit == AXIS_FIRST) begin
                e_s[i] = r_as[i]; e_m[i] = r_am[i];
            end else if (r_emit == AXIS_SECOND) begin
                e_s[i] = r_ss[i]; e_m[i] = r_sm[i];
            end else begin
                e_s[i] = r_ns[i]; e_m[i] = r_nm[i];
            end
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        logic signed [MAG_W-1:0] term;
        term      = $signed(MAG_W'(r_prod));
        acc_new   = (r_step[0] ? r_acc : '0) + (r_pneg ? -term : term);
        sumsq_new = (r_step == 3'd0 ? '0 : r_sumsq) + MAG_W'(r_prod);
        rt_trial  = {1'b0, r_root} + {1'b0, r_bitv};
        rt_ge     = {1'b0, r_x} >= rt_trial;
        root_new  = rt_ge ? (r_root >> 1) + r_bitv : (r_root >> 1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:    if (i_q_valid) n_state = BK_RESCALE;
            BK_RESCALE: begin
                if (rs_done) begin
                    unique case (r_phase)
                        PH_A:    n_state = BK_RESCALE;
                        PH_B:    n_state = BK_XMUL;
                        PH_N:    n_state = BK_XMUL;
                        default: n_state = BK_SQMUL;
                    endcase
                end
            end
            BK_XMUL:    n_state = BK_XACC;
            BK_XACC:    n_state = (r_step == XSTEP_LAST) ? BK_RESCALE : BK_XMUL;
            BK_SQMUL:   n_state = BK_SQACC;
            BK_SQACC: begin
                if (r_step == SQSTEP_LAST) begin
                    n_state = (sumsq_new == '0) ? BK_OUT : BK_ROOT;
                end else begin
                    n_state = BK_SQMUL;
                end
            end
            BK_ROOT:    if (r_bitv[0]) n_state = BK_DIV;
            BK_DIV:     if (r_cnt == CNT_W'(Q_W - 1)) n_state = BK_OUT;
            BK_OUT: begin
                if (out_load) begin
                    n_state = (r_emit == AXIS_NORMAL) ? BK_IDLE : BK_SQMUL;
                end
            end
            default:    n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            BK_IDLE:  o_q_pop = i_q_valid;
            BK_XMUL: begin
                mul_a = r_step[0] ? p_m[idx_k] : p_m[idx_j];
                mul_b = r_step[0] ? q_m[idx_j] : q_m[idx_k];
            end
            BK_SQMUL: begin
                mul_a = e_m[r_step[1:0]];
                mul_b = e_m[r_step[1:0]];
            end
            BK_OUT:   out_load = !r_out_valid || i_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_phase <= PH_A;
            r_emit  <= AXIS_FIRST;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                BK_IDLE: begin
                    r_phase <= PH_A;
                    r_emit  <= AXIS_FIRST;
                end
                BK_RESCALE: begin
                    if (rs_done) begin
                        r_step <= '0;
                        unique case (r_phase)
                            PH_A:    r_phase <= PH_B;
                            PH_B:    r_phase <= PH_N;
                            PH_N:    r_phase <= PH_S;
                            default: r_phase <= PH_S;
                        endcase
                    end
                end
                BK_XACC, BK_SQACC: r_step <= r_step + 3'd1;
                BK_OUT: begin
                    if (out_load) begin
                        r_emit <= (r_emit == AXIS_NORMAL) ? AXIS_FIRST : r_emit + 2'd1;
                        r_step <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        logic [NUM_W-1:0] numer;
        logic [NRM_W+1:0] trial;
        unique case (r_state)
            BK_IDLE: begin
                r_bsum <= i_q_data.second;
                for (int i = 0; i < 3; i++) begin
                    r_vs[i] <= i_q_data.first[i][SUM_W-1];
                    r_vm[i] <= MAG_W'($unsigned(i_q_data.first[i][SUM_W-1] ?
                               -i_q_data.first[i] : i_q_data.first[i]));
                end
            end
            BK_RESCALE: begin
                if (rs_done) begin
                    for (int i = 0; i < 3; i++) begin
                        unique case (r_phase)
                            PH_A: begin
                                r_as[i] <= r_vs[i];
                                r_am[i] <= r_vm[i][NRM_W-1:0];
                                r_vs[i] <= r_bsum[i][SUM_W-1];
                                r_vm[i] <= MAG_W'($unsigned(r_bsum[i][SUM_W-1] ?
                                           -r_bsum[i] : r_bsum[i]));
                            end
                            PH_B: begin
                                r_bs[i] <= r_vs[i];
                                r_bm[i] <= r_vm[i][NRM_W-1:0];
                            end
                            PH_N: begin
                                r_ns[i] <= r_vs[i];
                                r_nm[i] <= r_vm[i][NRM_W-1:0];
                            end
                            default: begin
                                r_ss[i] <= r_vs[i];
                                r_sm[i] <= r_vm[i][NRM_W-1:0];
                            end
                        endcase
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        priority if (|vor[MAG_W-1:NRM_W+4]) begin
                            r_vm[i] <= r_vm[i] >> 4;
                        end else if (|vor[MAG_W-1:NRM_W]) begin
                            r_vm[i] <= r_vm[i] >> 1;
                        end else if (vor[NRM_W-1:NRM_W-4] == 4'd0) begin
                            r_vm[i] <= r_vm[i] << 4;
                        end else begin
                            r_vm[i] <= r_vm[i] << 1;
                        end
                    end
                end
            end
            BK_XMUL, BK_SQMUL: begin
                r_prod <= mul_p;
                r_pneg <= x_neg;
            end
            BK_XACC: begin
                r_acc <= acc_new;
                if (r_step[0]) begin
                    r_vs[idx_i] <= acc_new[MAG_W-1];
                    r_vm[idx_i] <= acc_new[MAG_W-1] ? MAG_W'(-acc_new) : MAG_W'(acc_new);
                end
            end
            BK_SQACC: begin
                r_sumsq <= sumsq_new;
                r_x     <= sumsq_new;
                r_root  <= '0;
                r_bitv  <= MAG_W'(1) << (MAG_W - 2);
                r_cnt   <= '0;
                r_degen <= (sumsq_new == '0);
                for (int i = 0; i < 3; i++) begin
                    r_quo[i] <= '0;
                end
            end
            BK_ROOT: begin
                if (rt_ge) begin
                    r_x <= r_x - rt_trial[MAG_W-1:0];
                end
                r_root <= root_new;
                r_bitv <= r_bitv >> 2;
                r_len  <= root_new[NRM_W:0];
                for (int i = 0; i < 3; i++) begin
                    numer = (NUM_W'(e_m[i]) << UNIT_FRAC_BITS)
                          + NUM_W'(root_new[NRM_W:1]);
                    r_rem[i] <= (NRM_W+1)'(numer[NUM_W-1:Q_W]);
                    r_num[i] <= numer[Q_W-1:0];
                end
            end
            BK_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                for (int i = 0; i < 3; i++) begin
                    trial = {r_rem[i], r_num[i][Q_W-1]};
                    if (trial >= {1'b0, r_len}) begin
                        r_rem[i] <= (NRM_W+1)'(trial - {1'b0, r_len});
                        r_quo[i] <= {r_quo[i][Q_W-2:0], 1'b1};
                    end else begin
                        r_rem[i] <= trial[NRM_W:0];
                        r_quo[i] <= {r_quo[i][Q_W-2:0], 1'b0};
                    end
                    r_num[i] <= r_num[i] << 1;
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_axis  <= r_emit;
            r_out_degen <= r_degen;
            r_out_end   <= (r_emit == AXIS_NORMAL);
            for (int i = 0; i < 3; i++) begin
                r_out_unit[i] <= e_s[i] ? UNIT_W'(-UNIT_W'(r_quo[i])) : UNIT_W'(r_quo[i]);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_axis  = r_out_axis;
    assign o_unit  = r_out_unit;
    assign o_degen = r_out_degen;
    assign o_end   = r_out_end;

`ifndef SYNTHESIS
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == BK_RESCALE) && (r_phase == PH_A))
        else $error("frame pop did not start rescale of first axis");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_len != '0))
        else $error("division with zero length");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit == AXIS_FIRST) || (r_emit == AXIS_SECOND) || (r_emit == AXIS_NORMAL))
        else $error("axis counter out of range");
    a_end_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_end == (r_out_axis == AXIS_NORMAL)))
        else $error("frame end not on normal");
`endif

endmodule
